// ===== sv/icp_pkg.sv =====
package icp_pkg;

  localparam int unsigned MemDepthDef = 1024;

  localparam int unsigned DataW   = 64;
  localparam int unsigned PlenW   = 11;
  localparam int unsigned PcOutW  = 10;
  localparam int unsigned LdAddrW = 10;
  localparam int unsigned NDigits = 5;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_EXEC = 2'd1,
    CMD_EXIN = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OUTPUT    = 3'd1,
    ST_NEED_IN   = 3'd2,
    ST_HALTED    = 3'd3,
    ST_BAD_OP    = 3'd4,
    ST_BAD_ADDR  = 3'd5
  } status_e;

  // opcodes in BCD: tens digit above units digit
  typedef enum logic [7:0] {
    OP_ADD  = 8'h01,
    OP_MUL  = 8'h02,
    OP_IN   = 8'h03,
    OP_OUT  = 8'h04,
    OP_JT   = 8'h05,
    OP_JF   = 8'h06,
    OP_LT   = 8'h07,
    OP_EQ   = 8'h08,
    OP_ARB  = 8'h09,
    OP_HALT = 8'h99
  } op_e;

  localparam logic [3:0] MODE_POS = 4'd0;
  localparam logic [3:0] MODE_IMM = 4'd1;
  localparam logic [3:0] MODE_REL = 4'd2;

  // low five decimal digits of an instruction word, digit 0 is units
  typedef struct packed {
    logic                   done;
    logic [NDigits-1:0][3:0] digits;
  } dig_res_t;

endpackage

// ===== sv/icp_digits.sv =====
module icp_digits (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [62:0]               word_i,
  output icp_pkg::dig_res_t         res_o
);

  // shift-add-3 conversion, four bits a cycle; the carry out of the top
  // digit is dropped, leaving the word mod 100000
  localparam int unsigned BcdW = icp_pkg::NDigits * 4;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [63:0]     sh_q, sh_d;
  logic [BcdW-1:0] bcd_q, bcd_d;

  function automatic logic [BcdW-1:0] add3(input logic [BcdW-1:0] b);
    logic [BcdW-1:0] r;
    r = b;
    for (int k = 0; k < int'(icp_pkg::NDigits); k++) begin
      if (b[4*k +: 4] >= 4'd5) begin
        r[4*k +: 4] = b[4*k +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [BcdW-1:0] t;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    t      = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = {1'b0, word_i};
      bcd_d  = '0;
    end else if (busy_q) begin
      for (int s = 0; s < 4; s++) begin
        t = add3(t);
        t = {t[BcdW-2:0], sh_q[63-s]};
      end
      bcd_d = t;
      sh_d  = {sh_q[59:0], 4'b0};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

  assign res_o.done   = done_q;
  assign res_o.digits = bcd_q;

endmodule

// ===== sv/intcode_processor_step_unit.sv =====
// Channel    | Handshake                | Payload
// -----------+--------------------------+----------------------------------
// request    | start, busy              | cmd_i, addr_i, value_i
// result     | done_o (one-cycle strobe)| status_o, out_value_o, pc_now_o
// config     | psel/penable/pwrite/...  | program_length at byte address 0
//
// A load or an unused command ends in its accept cycle; its result strobes the next
// cycle and busy never rises, so loads can stream one a cycle while no execute is busy.
// An execute that halts or faults on the pc or halt flag alone also ends in
// its accept cycle. Otherwise it runs the instruction fetch, the wait on the
// 16-step decimal digit extraction, a resolve step per parameter plus a
// pointer read when not immediate, the operand reads and the write back,
// all through the one memory port; multiply steps through a shared
// 32x32 multiplier in place of the execute state.
// Reset clears pc, relative base, halt flag and program length; memory is
// not cleared. The receiver cannot stall: done_o is strobed, and status and value hold only until the next result.
module intcode_processor_step_unit #(
  parameter int unsigned MEM_DEPTH = icp_pkg::MemDepthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            cmd_i,
  input  logic [icp_pkg::LdAddrW-1:0]           addr_i,
  input  logic signed [icp_pkg::DataW-1:0]      value_i,
  // result
  output logic                                  done_o,
  output logic [2:0]                            status_o,
  output logic signed [icp_pkg::DataW-1:0]      out_value_o,
  output logic [icp_pkg::PcOutW-1:0]            pc_now_o,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [1:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam logic [63:0]   DepthW  = 64'(MEM_DEPTH);
  localparam logic [AW:0]   DepthL  = (AW+1)'(MEM_DEPTH);

  // one-hot sequencer
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_INSTR = 10'b00_0000_0010,  // instruction word arriving
    S_DEC   = 10'b00_0000_0100,  // waiting on digit extraction
    S_PARAM = 10'b00_0000_1000,  // resolve parameter, maybe read pointer
    S_PRD   = 10'b00_0001_0000,  // pointer word arriving
    S_OPA   = 10'b00_0010_0000,  // input write, or read operand a
    S_ARD   = 10'b00_0100_0000,
    S_BRD   = 10'b00_1000_0000,
    S_EXEC  = 10'b01_0000_0000,
    S_MUL   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [63:0]             pc_q, pc_d;
  logic [63:0]             rb_q, rb_d;
  logic                    halted_q, halted_d;
  logic [icp_pkg::PlenW-1:0] plen_q;
  logic                    cmd2_q, cmd2_d;
  logic [63:0]             val_q, val_d;
  icp_pkg::op_e            op_q, op_d;
  logic [2:0][3:0]         modes_q, modes_d;
  logic [1:0]              np_q, np_d;
  logic [1:0]              pi_q, pi_d;
  logic [2:0][AW-1:0]      adr_q, adr_d;
  logic [63:0]             a_q, a_d;
  logic [63:0]             b_q, b_d;
  logic [1:0]              mcnt_q, mcnt_d;
  logic [63:0]             mp_q, mp_d;
  logic [63:0]             acc_q, acc_d;

  logic                    done_q, done_d;
  icp_pkg::status_e        status_q, status_d;
  logic [63:0]             outv_q, outv_d;

  // single-port word store
  logic [63:0]             mem_q [MEM_DEPTH];
  logic                    mem_we;
  logic [AW-1:0]           mem_addr;
  logic [63:0]             mem_wdata;
  logic [63:0]             rdata_q;

  logic                    dig_start;
  icp_pkg::dig_res_t       dig_res;

  icp_digits u_digits (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dig_start),
    .word_i (rdata_q[62:0]),
    .res_o  (dig_res)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  // configuration port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(plen_q) : 32'd0;

  always_comb begin
    logic             fin;
    icp_pkg::status_e fst;
    logic [3:0]       m;
    logic             wr;
    logic [AW:0]      loc;
    logic [63:0]      ea;
    logic [7:0]       opb;
    logic [31:0]      mx, my;
    logic [63:0]      prod;
    logic [63:0]      sum;

    state_d   = state_q;
    pc_d      = pc_q;
    rb_d      = rb_q;
    halted_d  = halted_q;
    cmd2_d    = cmd2_q;
    val_d     = val_q;
    op_d      = op_q;
    modes_d   = modes_q;
    np_d      = np_q;
    pi_d      = pi_q;
    adr_d     = adr_q;
    a_d       = a_q;
    b_d       = b_q;
    mcnt_d    = mcnt_q;
    mp_d      = mp_q;
    acc_d     = acc_q;
    mem_we    = 1'b0;
    mem_addr  = pc_q[AW-1:0];
    mem_wdata = val_q;
    dig_start = 1'b0;
    fin       = 1'b0;
    fst       = icp_pkg::ST_OK;
    m         = modes_q[pi_q];
    wr        = (pi_q == 2'd2) || (op_q == icp_pkg::OP_IN && pi_q == 2'd0);
    loc       = {1'b0, pc_q[AW-1:0]} + (AW+1)'(pi_q) + (AW+1)'(1);
    ea        = (m == icp_pkg::MODE_POS) ? rdata_q : rb_q + rdata_q;
    opb       = {dig_res.digits[1], dig_res.digits[0]};
    mx        = (mcnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
    my        = (mcnt_q == 2'd1) ? b_q[63:32] : b_q[31:0];
    prod      = 64'(mx) * 64'(my);
    sum       = acc_q + {mp_q[31:0], 32'b0};

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (icp_pkg::cmd_e'(cmd_i))
            icp_pkg::CMD_LOAD: begin
              if (64'(addr_i) < DepthW) begin
                mem_we    = 1'b1;
                mem_addr  = AW'(addr_i);
                mem_wdata = value_i;
              end
              fin = 1'b1;
            end
            icp_pkg::CMD_EXEC, icp_pkg::CMD_EXIN: begin
              cmd2_d = (icp_pkg::cmd_e'(cmd_i) == icp_pkg::CMD_EXIN);
              val_d  = value_i;
              if (halted_q) begin
                fin = 1'b1;
                fst = icp_pkg::ST_HALTED;
              end else if (pc_q[63]) begin
                fin = 1'b1;
                fst = icp_pkg::ST_BAD_ADDR;
              end else if (pc_q >= 64'(plen_q)) begin
                halted_d = 1'b1;
                fin      = 1'b1;
                fst      = icp_pkg::ST_HALTED;
              end else if (pc_q >= DepthW) begin
                fin = 1'b1;
                fst = icp_pkg::ST_BAD_ADDR;
              end else begin
                state_d = S_INSTR;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_INSTR: begin
        if (rdata_q[63]) begin
          fin = 1'b1;
          fst = icp_pkg::ST_BAD_OP;
        end else begin
          dig_start = 1'b1;
          state_d   = S_DEC;
        end
      end
      S_DEC: begin
        if (dig_res.done) begin
          op_d    = icp_pkg::op_e'(opb);
          modes_d = dig_res.digits[4:2];
          pi_d    = 2'd0;
          state_d = S_PARAM;
          case (opb)
            icp_pkg::OP_ADD, icp_pkg::OP_MUL, icp_pkg::OP_LT, icp_pkg::OP_EQ: np_d = 2'd3;
            icp_pkg::OP_JT, icp_pkg::OP_JF: np_d = 2'd2;
            icp_pkg::OP_IN, icp_pkg::OP_OUT, icp_pkg::OP_ARB: np_d = 2'd1;
            icp_pkg::OP_HALT: begin
              halted_d = 1'b1;
              fin      = 1'b1;
              fst      = icp_pkg::ST_HALTED;
            end
            default: begin
              fin = 1'b1;
              fst = icp_pkg::ST_BAD_OP;
            end
          endcase
        end
      end
      S_PARAM: begin
        if (m > icp_pkg::MODE_REL || (wr && m == icp_pkg::MODE_IMM)) begin
          fin = 1'b1;
          fst = icp_pkg::ST_BAD_OP;
        end else if (loc >= DepthL) begin
          fin = 1'b1;
          fst = icp_pkg::ST_BAD_ADDR;
        end else if (m == icp_pkg::MODE_IMM) begin
          adr_d[pi_q] = loc[AW-1:0];
          if (pi_q + 2'd1 == np_q) begin
            state_d = S_OPA;
          end else begin
            pi_d = pi_q + 2'd1;
          end
        end else begin
          mem_addr = loc[AW-1:0];
          state_d  = S_PRD;
        end
      end
      S_PRD: begin
        if (ea >= DepthW) begin
          fin = 1'b1;
          fst = icp_pkg::ST_BAD_ADDR;
        end else begin
          adr_d[pi_q] = ea[AW-1:0];
          if (pi_q + 2'd1 == np_q) begin
            state_d = S_OPA;
          end else begin
            pi_d    = pi_q + 2'd1;
            state_d = S_PARAM;
          end
        end
      end
      S_OPA: begin
        if (op_q == icp_pkg::OP_IN) begin
          fin = 1'b1;
          if (!cmd2_q) begin
            fst = icp_pkg::ST_NEED_IN;
          end else begin
            mem_we    = 1'b1;
            mem_addr  = adr_q[0];
            mem_wdata = val_q;
            pc_d      = pc_q + 64'd2;
          end
        end else begin
          mem_addr = adr_q[0];
          state_d  = S_ARD;
        end
      end
      S_ARD: begin
        a_d = rdata_q;
        if (np_q >= 2'd2) begin
          mem_addr = adr_q[1];
          state_d  = S_BRD;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_BRD: begin
        b_d = rdata_q;
        if (op_q == icp_pkg::OP_MUL) begin
          mcnt_d  = 2'd0;
          state_d = S_MUL;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        fin       = 1'b1;
        mem_addr  = adr_q[2];
        case (op_q)
          icp_pkg::OP_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = a_q + b_q;
            pc_d      = pc_q + 64'd4;
          end
          icp_pkg::OP_LT: begin
            mem_we    = 1'b1;
            mem_wdata = 64'($signed(a_q) < $signed(b_q));
            pc_d      = pc_q + 64'd4;
          end
          icp_pkg::OP_EQ: begin
            mem_we    = 1'b1;
            mem_wdata = 64'(a_q == b_q);
            pc_d      = pc_q + 64'd4;
          end
          icp_pkg::OP_OUT: begin
            pc_d = pc_q + 64'd2;
            fst  = icp_pkg::ST_OUTPUT;
          end
          icp_pkg::OP_JT: pc_d = (a_q != 64'd0) ? b_q : pc_q + 64'd3;
          icp_pkg::OP_JF: pc_d = (a_q == 64'd0) ? b_q : pc_q + 64'd3;
          icp_pkg::OP_ARB: begin
            rb_d = rb_q + a_q;
            pc_d = pc_q + 64'd2;
          end
          default: begin
          end
        endcase
      end
      S_MUL: begin
        // three cross products, the high-by-high one cannot reach 64 bits
        mp_d   = prod;
        mcnt_d = mcnt_q + 2'd1;
        if (mcnt_q == 2'd1) begin
          acc_d = mp_q;
        end else if (mcnt_q == 2'd2) begin
          acc_d = sum;
        end else if (mcnt_q == 2'd3) begin
          mem_we    = 1'b1;
          mem_addr  = adr_q[2];
          mem_wdata = sum;
          pc_d      = pc_q + 64'd4;
          fin       = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
    end
    done_d   = fin;
    status_d = fin ? fst : status_q;
    outv_d   = fin ? ((fst == icp_pkg::ST_OUTPUT) ? a_q : 64'd0) : outv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      rb_q     <= '0;
      halted_q <= 1'b0;
      plen_q   <= '0;
      done_q   <= 1'b0;
      status_q <= icp_pkg::ST_OK;
      mcnt_q   <= '0;
      pi_q     <= '0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      rb_q     <= rb_d;
      halted_q <= halted_d;
      done_q   <= done_d;
      status_q <= status_d;
      mcnt_q   <= mcnt_d;
      pi_q     <= pi_d;
      if (cfg_wr) begin
        plen_q <= pwdata[icp_pkg::PlenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd2_q  <= cmd2_d;
    val_q   <= val_d;
    op_q    <= op_d;
    modes_q <= modes_d;
    np_q    <= np_d;
    adr_q   <= adr_d;
    a_q     <= a_d;
    b_q     <= b_d;
    mp_q    <= mp_d;
    acc_q   <= acc_d;
    outv_q  <= outv_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_value_o = outv_q;
  assign pc_now_o    = pc_q[icp_pkg::PcOutW-1:0];

endmodule

// ===== sv/icp_checker.sv =====
module icp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        cmd_i,
  input logic                              done_o,
  input logic [2:0]                        status_o,
  input logic signed [icp_pkg::DataW-1:0]  out_value_o
);

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i == icp_pkg::CMD_LOAD |=> done_o && status_o == icp_pkg::ST_OK)
    else $error("load did not report ok in the next cycle");

  a_outv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != icp_pkg::ST_OUTPUT |-> out_value_o == 0)
    else $error("out_value non-zero without output");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !done_o)
    else $error("result strobed as an execute starts");

endmodule

bind intcode_processor_step_unit icp_checker u_icp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .cmd_i      (cmd_i),
  .done_o     (done_o),
  .status_o   (status_o),
  .out_value_o(out_value_o)
);
